[hw/rtl/sha1_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1 package
// types, constants and round helpers shared by the sha1 digest engine
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int NumChain   = 5;
  localparam int NumRounds  = 80;
  localparam int BlockWords = 16;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_PAD,
    ST_PAD_ZERO,
    ST_LENGTH,
    ST_EMIT
  } sha1_state_t;

  // controller to datapath
  typedef struct packed {
    logic       put_byte;     // write in_byte at fill position, count length
    logic       put_pad;      // write 0x80 at fill position, no length count
    logic       put_zero;     // write zero at fill position
    logic       put_length;   // load length into words 14 and 15
    logic       start_block;  // load working vars from chain
    logic       do_round;     // one compression round
    logic       finish_block; // fold working vars into chain
    logic       clear_msg;    // restore chain, clear length and fill
    logic       emit_shift;   // rotate chain toward output
  } sha1_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [5:0] fill;
    logic       last_round;
  } sha1_status_t;

  function automatic logic [31:0] sha1_f(input logic [6:0] r, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
    if (r < 7'd20) return (b & c) | (~b & d);
    if (r < 7'd40 || r >= 7'd60) return b ^ c ^ d;
    return (b & c) | (b & d) | (c & d);
  endfunction

  function automatic logic [31:0] sha1_k(input logic [6:0] r);
    if (r < 7'd20) return K0;
    if (r < 7'd40) return K1;
    if (r < 7'd60) return K2;
    return K3;
  endfunction

endpackage

[hw/rtl/sha1_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1 stream interfaces
// valid/ready channels for message bytes and digest words
// ----------------------------------------------------------------------------
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;
  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        last_word;
  modport source (output valid, digest_word, last_word, input ready);
  modport sink   (input valid, digest_word, last_word, output ready);
endinterface

[hw/rtl/sha1_digest_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1 digest engine top
// streaming SHA-1: bytes in, five digest words out per message
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  msg_in   in   data_byte, has_byte, end_of_message
//  dig_out  out  digest_word, last_word
//
//  byte beats are taken only while idle; the 64th byte of a block holds intake
//  for the 80 rounds of one shared round unit; the chain update runs in
//  the cycle after the last round, alongside whatever follows.
//  end of message adds padding and length writes, one or two blocks, the
//  chain update and five output beats.
//  reset is synchronous; output stalls hold the engine.
// ----------------------------------------------------------------------------
module sha1_digest_engine_top
  import sha1_pkg::*;
(
  input  logic clk,
  input  logic rst,
  sha1_in_if.sink    msg_in,
  sha1_out_if.source dig_out
);

  sha1_cmd_t    cmd;
  sha1_status_t status;
  logic         out_last;

  sha1_ctrl u_ctrl (
    .clk, .rst,
    .in_valid    (msg_in.valid),
    .in_has_byte (msg_in.has_byte),
    .in_eom      (msg_in.end_of_message),
    .in_ready    (msg_in.ready),
    .out_valid   (dig_out.valid),
    .out_last    (out_last),
    .out_ready   (dig_out.ready),
    .status      (status),
    .cmd         (cmd)
  );

  sha1_datapath u_dp (
    .clk, .rst,
    .cmd       (cmd),
    .in_byte   (msg_in.data_byte),
    .status    (status),
    .head_word (dig_out.digest_word)
  );

  assign dig_out.last_word = out_last;

endmodule

[hw/rtl/sha1_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1 datapath
// block buffer, schedule, round logic, chaining value and length counter
// ----------------------------------------------------------------------------
module sha1_datapath
  import sha1_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  sha1_cmd_t    cmd,
  input  logic [7:0]   in_byte,
  output sha1_status_t status,
  output logic [31:0]  head_word
);

  logic [31:0] buf_w [BlockWords];
  logic [31:0] chain [NumChain];
  logic [31:0] wv    [NumChain];
  logic [5:0]  fill;
  logic [63:0] bit_len;
  logic [6:0]  round_idx;

  logic [3:0]  s;
  logic [31:0] w_new, w_cur, tmp, wr_word;
  logic [7:0]  wr_val;
  logic [3:0]  wr_idx;
  logic [4:0]  wr_shift;

  assign s     = round_idx[3:0];
  assign w_new = buf_w[s + 4'd13] ^ buf_w[s + 4'd8] ^ buf_w[s + 4'd2] ^ buf_w[s];
  assign w_cur = (round_idx >= 7'd16) ? {w_new[30:0], w_new[31]} : buf_w[s];
  assign tmp   = {wv[0][26:0], wv[0][31:27]} + sha1_f(round_idx, wv[1], wv[2], wv[3])
               + wv[4] + w_cur + sha1_k(round_idx);

  assign wr_val   = cmd.put_byte ? in_byte : (cmd.put_pad ? PAD_BYTE : 8'h00);
  assign wr_idx   = fill[5:2];
  assign wr_shift = 5'd24 - {fill[1:0], 3'b000};
  assign wr_word  = (buf_w[wr_idx] & ~(32'hFF << wr_shift))
                  | ({24'h0, wr_val} << wr_shift);

  assign status.fill       = fill;
  assign status.last_round = (round_idx == 7'(NumRounds - 1));
  assign head_word         = chain[0];

  always_ff @(posedge clk) begin
    if (cmd.put_byte || cmd.put_pad || cmd.put_zero) begin
      buf_w[wr_idx] <= wr_word;
    end else if (cmd.put_length) begin
      buf_w[14] <= bit_len[63:32];
      buf_w[15] <= bit_len[31:0];
    end else if (cmd.do_round && round_idx >= 7'd16) begin
      buf_w[s] <= w_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      bit_len   <= '0;
      round_idx <= '0;
      chain[0] <= H0_INIT; chain[1] <= H1_INIT; chain[2] <= H2_INIT;
      chain[3] <= H3_INIT; chain[4] <= H4_INIT;
      for (int i = 0; i < NumChain; i++) wv[i] <= '0;
    end else begin
      if (cmd.put_byte) bit_len <= bit_len + 64'd8;
      if (cmd.put_byte || cmd.put_pad || cmd.put_zero) fill <= fill + 6'd1;
      if (cmd.start_block) begin
        round_idx <= '0;
        for (int i = 0; i < NumChain; i++) wv[i] <= chain[i];
      end
      if (cmd.do_round) begin
        round_idx <= round_idx + 7'd1;
        wv[4] <= wv[3];
        wv[3] <= wv[2];
        wv[2] <= {wv[1][1:0], wv[1][31:2]};
        wv[1] <= wv[0];
        wv[0] <= tmp;
      end
      if (cmd.finish_block) begin
        for (int i = 0; i < NumChain; i++) chain[i] <= chain[i] + wv[i];
      end
      if (cmd.emit_shift) begin
        for (int i = 0; i < NumChain - 1; i++) chain[i] <= chain[i + 1];
        chain[NumChain - 1] <= chain[0];
      end
      if (cmd.clear_msg) begin
        fill    <= '0;
        bit_len <= '0;
        chain[0] <= H0_INIT; chain[1] <= H1_INIT; chain[2] <= H2_INIT;
        chain[3] <= H3_INIT; chain[4] <= H4_INIT;
      end
    end
  end

  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.do_round |-> round_idx < 7'(NumRounds)) else $error("round past 79");
  a_len_step: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.put_byte) && !$past(cmd.clear_msg) |-> bit_len == $past(bit_len) + 64'd8)
    else $error("length not counted");
  a_start_round0: assert property (@(posedge clk) disable iff (rst)
    cmd.start_block |=> round_idx == '0) else $error("round not cleared");

endmodule

[hw/rtl/sha1_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1 controller
// sequences byte intake, padding, compression and digest output
// ----------------------------------------------------------------------------
module sha1_ctrl
  import sha1_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_has_byte,
  input  logic         in_eom,
  output logic         in_ready,
  output logic         out_valid,
  output logic         out_last,
  input  logic         out_ready,
  input  sha1_status_t status,
  output sha1_cmd_t    cmd
);

  sha1_state_t state, state_next;
  logic        final_blk, final_blk_next; // block in flight is the last of the message
  logic        pad_pend, pad_pend_next;   // eom seen, padding still to do
  logic        zero_pend, zero_pend_next; // zero fill resumes after the block
  logic [2:0]  emit_cnt;
  logic        fold;

  logic take;
  assign take = in_valid && in_ready;

  // next state
  always_comb begin
    state_next     = state;
    final_blk_next = final_blk;
    pad_pend_next  = pad_pend;
    zero_pend_next = zero_pend;
    case (state)
      ST_IDLE: begin
        if (take) begin
          if (in_has_byte && status.fill == 6'd63) begin
            state_next     = ST_ROUND;
            final_blk_next = 1'b0;
            pad_pend_next  = in_eom;
          end else if (in_eom) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (status.last_round) begin
          if (final_blk)      state_next = ST_EMIT;
          else if (pad_pend)  state_next = ST_PAD;
          else if (zero_pend) state_next = ST_PAD_ZERO;
          else                state_next = ST_IDLE;
          pad_pend_next  = 1'b0;
          zero_pend_next = 1'b0;
        end
      end
      ST_PAD: begin
        // pad byte in the last slot closes the block at once
        if (status.fill == 6'd63) begin
          state_next     = ST_ROUND;
          final_blk_next = 1'b0;
          zero_pend_next = 1'b1;
        end else begin
          state_next = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        if (status.fill == 6'd56) state_next = ST_LENGTH;
        else if (status.fill == 6'd63) begin
          state_next     = ST_ROUND;
          final_blk_next = 1'b0;
          pad_pend_next  = 1'b0;
          zero_pend_next = 1'b1;
        end
      end
      ST_LENGTH: begin
        state_next     = ST_ROUND;
        final_blk_next = 1'b1;
      end
      ST_EMIT: begin
        if (!fold && out_ready && emit_cnt == 3'(NumChain - 1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // the zero fill after a second-block wrap restarts at fill 0 and ends at 56
  logic start_now;
  assign start_now = (state_next == ST_ROUND) && (state != ST_ROUND);

  // outputs
  always_comb begin
    cmd       = '0;
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_EMIT) && !fold;
    out_last  = (emit_cnt == 3'(NumChain - 1));
    case (state)
      ST_IDLE:     cmd.put_byte = take && in_has_byte;
      ST_ROUND:    cmd.do_round = 1'b1;
      ST_PAD:      cmd.put_pad  = 1'b1;
      ST_PAD_ZERO: cmd.put_zero = (status.fill != 6'd56);
      ST_LENGTH:   cmd.put_length = 1'b1;
      ST_EMIT: begin
        cmd.emit_shift = out_valid && out_ready;
        cmd.clear_msg  = out_valid && out_ready && out_last;
      end
      default: ;
    endcase
    cmd.start_block  = start_now;
    cmd.finish_block = fold;
  end

  // fold happens the cycle after the last round
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      final_blk <= 1'b0;
      pad_pend  <= 1'b0;
      zero_pend <= 1'b0;
      emit_cnt  <= '0;
      fold      <= 1'b0;
    end else begin
      state     <= state_next;
      final_blk <= final_blk_next;
      pad_pend  <= pad_pend_next;
      zero_pend <= zero_pend_next;
      fold      <= (state == ST_ROUND) && status.last_round;
      if (state == ST_EMIT && !fold && out_ready)
        emit_cnt <= (emit_cnt == 3'(NumChain - 1)) ? 3'd0 : emit_cnt + 3'd1;
    end
  end

  a_emit_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == ST_EMIT && !in_ready) else $error("emit overlaps intake");
  a_emit_cnt: assert property (@(posedge clk) disable iff (rst)
    state != ST_EMIT |-> emit_cnt == '0) else $error("emit count stale");
  a_fold_once: assert property (@(posedge clk) disable iff (rst)
    fold |-> state != ST_ROUND) else $error("fold during rounds");

endmodule

[tb/sha1_digest_engine_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1 digest engine testbench
// streams messages of many lengths through the engine with random gaps and
// output stalls; a software sha-1 model predicts the five words per message
// ----------------------------------------------------------------------------
module sha1_digest_engine_top_test;
  import sha1_pkg::*;

  logic clk;
  logic rst;

  sha1_in_if  msg_in();
  sha1_out_if dig_out();

  sha1_digest_engine_top uut (
    .clk(clk),
    .rst(rst),
    .msg_in(msg_in),
    .dig_out(dig_out)
  );

  // predictor state
  logic [31:0] msg_block [16];
  logic [5:0]  msg_fill;
  logic [63:0] msg_bits;
  logic [31:0] chain [5];

  logic [31:0] digest_q [$];
  logic        last_q [$];

  int mismatches;
  int words_seen;
  int msgs_sent;
  int bytes_sent;
  int items_sent;
  bit sending_done;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] a, b, c, d, e, w, f, k, t;
    logic [31:0] sched [80];
    for (int i = 0; i < 80; i++) begin
      if (i < 16) sched[i] = msg_block[i];
      else sched[i] = rol(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
    end
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      t = rol(a, 5) + f + e + sched[i] + k;
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endtask

  task automatic place_byte(input int pos, input logic [7:0] v);
    msg_block[pos / 4][8 * (3 - pos % 4) +: 8] = v;
  endtask

  task automatic restart_chain();
    chain[0] = H0_INIT; chain[1] = H1_INIT; chain[2] = H2_INIT;
    chain[3] = H3_INIT; chain[4] = H4_INIT;
    msg_fill = '0;
    msg_bits = '0;
  endtask

  task automatic predict_beat(input logic [7:0] v, input logic has, input logic eom);
    int pos;
    if (has) begin
      place_byte(msg_fill, v);
      msg_bits += 64'd8;
      msg_fill += 6'd1;
      if (msg_fill == 0) compress();
    end
    if (eom) begin
      pos = msg_fill;
      place_byte(pos, PAD_BYTE);
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin
          place_byte(pos, 8'h00);
          pos++;
        end
        compress();
        pos = 0;
      end
      while (pos < 56) begin
        place_byte(pos, 8'h00);
        pos++;
      end
      msg_block[14] = msg_bits[63:32];
      msg_block[15] = msg_bits[31:0];
      compress();
      for (int i = 0; i < 5; i++) begin
        digest_q.push_back(chain[i]);
        last_q.push_back(i == 4);
      end
      restart_chain();
      msgs_sent++;
    end
  endtask

  task automatic send_beat(input logic [7:0] v, input logic has, input logic eom);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      msg_in.valid          <= 1'b0;
      msg_in.data_byte      <= 8'($urandom_range(0, 255));
      msg_in.has_byte       <= 1'($urandom_range(0, 1));
      msg_in.end_of_message <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
    msg_in.valid          <= 1'b1;
    msg_in.data_byte      <= v;
    msg_in.has_byte       <= has;
    msg_in.end_of_message <= eom;
    @(posedge clk);
    while (!msg_in.ready) @(posedge clk);
    predict_beat(v, has, eom);
    if (has) bytes_sent++;
    items_sent++;
  endtask

  // message of n bytes; last byte carries the marker or a bare marker follows
  task automatic send_message(input int n, input bit random_bytes, input logic [7:0] fill);
    bit bare_end;
    bare_end = (n == 0) || $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      if (!bare_end && i == n - 1)
        send_beat(random_bytes ? 8'($urandom_range(0, 255)) : fill, 1'b1, 1'b1);
      else
        send_beat(random_bytes ? 8'($urandom_range(0, 255)) : fill, 1'b1, 1'b0);
      if ($urandom_range(0, 9) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end
    if (bare_end) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // output side: random stalls and in-order check
  initial begin
    int stall;
    dig_out.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        dig_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dig_out.ready <= 1'b1;
      @(posedge clk);
      while (!dig_out.valid) @(posedge clk);
      words_seen++;
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest beat %h", dig_out.digest_word);
      end else begin
        logic [31:0] exp_word;
        logic        exp_last;
        exp_word = digest_q.pop_front();
        exp_last = last_q.pop_front();
        if (dig_out.digest_word !== exp_word || dig_out.last_word !== exp_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: expected %h/%b got %h/%b", exp_word, exp_last,
                     dig_out.digest_word, dig_out.last_word);
        end
      end
    end
  end

  task automatic test_directed();
    send_beat(8'h00, 1'b0, 1'b0);
    send_message(0, 1'b0, 8'h00);
    send_message(1, 1'b0, 8'hff);
    send_message(3, 1'b0, 8'h00);
    send_message(3, 1'b0, 8'hff);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
  endtask

  task automatic test_block_edges();
    int sizes [4] = '{55, 56, 63, 64};
    foreach (sizes[i]) send_message(sizes[i], 1'b1, 8'h00);
  endtask

  task automatic test_random_messages();
    int n;
    while (items_sent < 400) begin
      n = $urandom_range(0, 4) == 0 ? $urandom_range(50, 80) : $urandom_range(0, 20);
      send_message(n, 1'b1, 8'h00);
    end
  endtask

  initial begin
    mismatches = 0; words_seen = 0; msgs_sent = 0; bytes_sent = 0; items_sent = 0;
    msg_in.valid = 1'b0;
    msg_in.data_byte = '0;
    msg_in.has_byte = 1'b0;
    msg_in.end_of_message = 1'b0;
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
    restart_chain();
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_block_edges();
    test_random_messages();
    msg_in.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("hashed %0d messages from %0d beats, %0d bytes, checked %0d digest words",
             msgs_sent, items_sent, bytes_sent, words_seen);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_stream_if.sv
hw/rtl/sha1_datapath.sv
hw/rtl/sha1_ctrl.sv
hw/rtl/sha1_digest_engine_top.sv
tb/sha1_digest_engine_top_test.sv
